// ----- rtl/set_assoc_cache_tag_lookup_assert.svh -----
// Assertion macros used by the checker of the cache tag lookup.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_ASSERT_SVH

// Same-cycle implication.
`define SACTL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sactl check failed");

// Next-cycle implication.
`define SACTL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sactl check failed");

`endif

// ----- rtl/sactl_pkg.sv -----
// Shared types, codes and helpers of the set-associative cache tag lookup.
// No dependencies; used by the controller, datapath, top level and checker.
package sactl_pkg;

  localparam logic ACTION_ACCESS = 1'b0;
  localparam logic ACTION_CLEAR  = 1'b1;

  localparam logic REG_REPLACE_LRU  = 1'b0;
  localparam logic REG_BLOCK_OFFSET = 1'b1;

  localparam logic [3:0] OFFSET_RESET = 4'd6;
  localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        action;
    logic [31:0] address;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [31:0] access_count;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [31:0] eviction_count;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic clear_stats;
    logic read;
    logic update;
    logic sweep;
    logic load_clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic out_free;
    logic sweep_last;
  } dp_status_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == SAT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

// ----- rtl/sactl_ctrl.sv -----
// Sequencer of the cache tag lookup: handshakes, row read, update, clear sweep.
// Depends on sactl_pkg for the command and status structs.
module sactl_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  sactl_pkg::dp_status_t  status_i,
  output sactl_pkg::ctrl_cmd_t   cmd_o
);
  import sactl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_UPD   = 5'b00100,
    S_SWEEP = 5'b01000,
    S_FLUSH = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   emit_q, emit_d;
  logic   accept;

  always_comb begin
    state_d    = state_q;
    emit_d     = emit_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        accept     = in_valid_i;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_UPD;
      end
      S_UPD: begin
        // finish the word only when the output register can take the result
        if (status_i.out_free) begin
          cmd_o.update = 1'b1;
          in_ready_o   = 1'b1;
          accept       = in_valid_i;
          state_d      = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = emit_q ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.load_clear = 1'b1;
          emit_d           = 1'b0;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (accept) begin
      cmd_o.capture = 1'b1;
      if (status_i.in_clear == ACTION_CLEAR) begin
        cmd_o.clear_stats = 1'b1;
        emit_d            = 1'b1;
        state_d           = S_SWEEP;
      end else begin
        state_d = S_READ;
      end
    end
  end

  // Reset starts with a sweep that invalidates every row and emits nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      emit_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
    end
  end

endmodule

// ----- rtl/sactl_dpath.sv -----
// Datapath of the cache tag lookup: tag/stamp row memory, compare, victim pick,
// statistics counters and output register. Depends on sactl_pkg.
module sactl_dpath #(
  parameter int NUM_SETS = 64,
  parameter int WAYS     = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   replace_lru_i,
  input  logic [3:0]             block_offset_i,
  input  sactl_pkg::in_item_t    in_item_i,
  input  sactl_pkg::ctrl_cmd_t   cmd_i,
  output sactl_pkg::dp_status_t  status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sactl_pkg::out_item_t   out_item_o
);
  import sactl_pkg::*;

  localparam int SET_BITS = $clog2(NUM_SETS);
  localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef struct packed {
    logic [WAYS-1:0]       valid;
    logic [WAYS-1:0][31:0] tag;
    logic [WAYS-1:0][31:0] stamp;
  } row_t;

  row_t        row_mem_q [NUM_SETS];
  row_t        rd_row_q;
  row_t        new_row;
  logic [31:0] block_q;
  logic [SET_W-1:0] set_idx;
  logic [SET_W-1:0] sweep_q;
  logic [31:0] tag_full;

  logic [31:0] timer_q, timer_inc;
  logic [31:0] acc_q, hit_q, miss_q, evict_q;
  logic [31:0] acc_inc, hit_next, miss_next, evict_next;

  logic [WAYS-1:0]  hit_vec, vict_vec;
  logic             hit, has_inv, evict;
  logic [WAY_W-1:0] hit_way, inv_way, vict_way, fill_way;

  logic      out_valid_q;
  out_item_t out_item_q;

  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  row_t             mem_wdata;

  if (SET_BITS == 0) begin : g_one_set
    assign set_idx = '0;
  end else begin : g_sets
    assign set_idx = block_q[SET_BITS-1:0];
  end

  assign tag_full = block_q >> SET_BITS;

  // Capture the block number of the word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      block_q <= in_item_i.address >> block_offset_i;
    end
  end

  // Compare, fill and victim selection on the registered row.
  always_comb begin
    hit_vec  = '0;
    vict_vec = '0;
    hit_way  = '0;
    inv_way  = '0;
    vict_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = rd_row_q.valid[w] && (rd_row_q.tag[w] == tag_full);
      vict_vec[w] = 1'b1;
      for (int j = 0; j < WAYS; j++) begin
        // oldest stamp wins, the lower way on a tie
        if (j < w && !(rd_row_q.stamp[w] < rd_row_q.stamp[j])) begin
          vict_vec[w] = 1'b0;
        end
        if (j > w && !(rd_row_q.stamp[w] <= rd_row_q.stamp[j])) begin
          vict_vec[w] = 1'b0;
        end
      end
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!rd_row_q.valid[w]) begin
        inv_way = WAY_W'(w);
      end
      if (vict_vec[w]) begin
        vict_way = WAY_W'(w);
      end
    end
    hit      = |hit_vec;
    has_inv  = ~&rd_row_q.valid;
    evict    = !hit && !has_inv;
    fill_way = has_inv ? inv_way : vict_way;

    timer_inc = timer_q + 32'd1;
    new_row   = rd_row_q;
    if (hit) begin
      if (replace_lru_i) begin
        new_row.stamp[hit_way] = timer_inc;
      end
    end else begin
      new_row.valid[fill_way] = 1'b1;
      new_row.tag[fill_way]   = tag_full;
      new_row.stamp[fill_way] = timer_inc;
    end

    acc_inc    = sat_inc(acc_q);
    hit_next   = hit ? sat_inc(hit_q) : hit_q;
    miss_next  = hit ? miss_q : sat_inc(miss_q);
    evict_next = evict ? sat_inc(evict_q) : evict_q;
  end

  // Single write port shared by the clear sweep and the update.
  assign mem_we    = cmd_i.sweep || cmd_i.update;
  assign mem_waddr = cmd_i.sweep ? sweep_q : set_idx;
  assign mem_wdata = cmd_i.sweep ? row_t'('0) : new_row;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.read) begin
      rd_row_q <= row_mem_q[set_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= status_o.sweep_last ? '0 : sweep_q + SET_W'(1);
    end
  end

  // Clear wins over an update retiring in the same cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
      acc_q   <= '0;
      hit_q   <= '0;
      miss_q  <= '0;
      evict_q <= '0;
    end else if (cmd_i.clear_stats) begin
      timer_q <= '0;
      acc_q   <= '0;
      hit_q   <= '0;
      miss_q  <= '0;
      evict_q <= '0;
    end else if (cmd_i.update) begin
      timer_q <= timer_inc;
      acc_q   <= acc_inc;
      hit_q   <= hit_next;
      miss_q  <= miss_next;
      evict_q <= evict_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update || cmd_i.load_clear) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      out_item_q.hit            <= hit;
      out_item_q.evicted        <= evict;
      out_item_q.access_count   <= acc_inc;
      out_item_q.hit_count      <= hit_next;
      out_item_q.miss_count     <= miss_next;
      out_item_q.eviction_count <= evict_next;
    end else if (cmd_i.load_clear) begin
      out_item_q <= '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign status_o.in_clear   = in_item_i.action;
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.sweep_last = (sweep_q == SET_W'(NUM_SETS - 1));

endmodule

// ----- rtl/set_assoc_cache_tag_lookup.sv -----
// Top level of the set-associative cache tag lookup with FIFO/LRU replacement.
// Holds the configuration registers; depends on sactl_pkg, sactl_ctrl, sactl_dpath.
//
//   channel  | signals                               | moves
//   ---------+---------------------------------------+---------------------------
//   input    | in_valid_i, in_ready_o, in_item_i     | access or clear word
//   output   | out_valid_o, out_ready_i, out_item_o  | hit/evicted and counters
//   config   | psel, penable, pwrite, paddr, pwdata, | replace_lru at 0,
//            | prdata, pready                        | block_offset_bits at 4
//
// An access reads the set's row from the tag memory in S_READ, then compares,
// picks the victim and writes the row back in S_UPD; the next word is accepted
// in S_UPD while the output is taken. A clear invalidates one row per cycle in
// S_SWEEP, then loads the cleared result in S_FLUSH. After reset the same sweep
// runs with in_ready_o low and emits nothing. A stalled output holds the
// next access in its compare cycle.
module set_assoc_cache_tag_lookup #(
  parameter int NUM_SETS = 64,
  parameter int WAYS     = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sactl_pkg::in_item_t   in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sactl_pkg::out_item_t  out_item_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import sactl_pkg::*;

  logic       replace_lru_q;
  logic [3:0] block_offset_q;
  logic       cfg_we;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      replace_lru_q  <= 1'b0;
      block_offset_q <= OFFSET_RESET;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_REPLACE_LRU:  replace_lru_q  <= pwdata[0];
        REG_BLOCK_OFFSET: block_offset_q <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_REPLACE_LRU:  prdata = {31'd0, replace_lru_q};
      REG_BLOCK_OFFSET: prdata = {28'd0, block_offset_q};
      default:          prdata = '0;
    endcase
  end

  sactl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sactl_dpath #(
    .NUM_SETS (NUM_SETS),
    .WAYS     (WAYS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .replace_lru_i  (replace_lru_q),
    .block_offset_i (block_offset_q),
    .in_item_i      (in_item_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_item_o     (out_item_o)
  );

endmodule

// ----- rtl/sactl_checker.sv -----
// Port-level checks of the cache tag lookup, bound to the top level.
// Depends on sactl_pkg and set_assoc_cache_tag_lookup_assert.svh.
`include "set_assoc_cache_tag_lookup_assert.svh"

module sactl_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input sactl_pkg::out_item_t out_item_o
);
  import sactl_pkg::*;

  logic [32:0] hit_miss_sum;

  assign hit_miss_sum = 33'(out_item_o.hit_count) + 33'(out_item_o.miss_count);

  // Hold the result until it is taken.
  `SACTL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  // A word never both hits and evicts.
  `SACTL_ASSERT_IMPL(a_hit_evict, out_valid_o, !(out_item_o.hit && out_item_o.evicted))
  // Below saturation every access is either a hit or a miss.
  `SACTL_ASSERT_IMPL(a_count_sum, out_valid_o && (out_item_o.access_count != SAT_MAX), hit_miss_sum == 33'(out_item_o.access_count))
  // Evictions only happen on misses.
  `SACTL_ASSERT_IMPL(a_evict_le_miss, out_valid_o, out_item_o.eviction_count <= out_item_o.miss_count)
  // An accepted word always makes the engine busy and drops in_ready_o.
  `SACTL_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind set_assoc_cache_tag_lookup sactl_checker u_checker (.*);
